// ----- src/wrrp_pkg.sv -----
`default_nettype none

package wrrp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_RIFF  = 2'd0;
  localparam logic [1:0] ERR_WAVE  = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  // Four-character codes as they appear little-endian in the shift word.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam int unsigned FMT_BODY_BYTES = 16;
  localparam int unsigned CNT_W          = $clog2(FMT_BODY_BYTES);

  // Depth of the queues on either side of the parser.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] byte_value;
    logic       file_start;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  sample_byte;
    logic        last_sample;
    logic [15:0] format_code;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
    logic [1:0]  error_code;
  } res_t;

endpackage

`default_nettype wire

// ----- src/wrrp_front.sv -----
`default_nettype none

module wrrp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire wrrp_pkg::in_item_t item,
  output logic                   full,
  output logic                   valid,
  output wrrp_pkg::in_item_t     head,
  input  wire logic              pop
);
  import wrrp_pkg::*;

  in_item_t            mem_r [QDEPTH];
  logic [QIDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

// ----- src/wrrp_parse.sv -----
`default_nettype none

module wrrp_parse (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire wrrp_pkg::in_item_t in_item,
  output logic                    in_pop,
  input  wire logic               res_ready,
  output logic                    res_valid,
  output wrrp_pkg::res_t          res
);
  import wrrp_pkg::*;

  localparam logic [3:0] PH_WAIT       = 4'd0;
  localparam logic [3:0] PH_RIFF_ID    = 4'd1;
  localparam logic [3:0] PH_RIFF_SIZE  = 4'd2;
  localparam logic [3:0] PH_WAVE_ID    = 4'd3;
  localparam logic [3:0] PH_CHUNK_ID   = 4'd4;
  localparam logic [3:0] PH_CHUNK_SIZE = 4'd5;
  localparam logic [3:0] PH_FMT_BODY   = 4'd6;
  localparam logic [3:0] PH_SKIP       = 4'd7;
  localparam logic [3:0] PH_DATA       = 4'd8;

  logic [3:0]       phase_r, phase_nxt, phase_v;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_v;
  logic [31:0]      shift_r, shift_nxt, shift_v;
  logic [31:0]      tag_r, tag_nxt;
  logic [31:0]      clen_r, clen_nxt, clen_dec;
  logic [15:0]      fmt_r, fmt_nxt, fmt_v;
  logic [15:0]      chan_r, chan_nxt, chan_v;
  logic [31:0]      rate_r, rate_nxt, rate_v;
  logic [15:0]      bits_r, bits_nxt, bits_v;
  logic [31:0]      drem_r, drem_nxt, drem_dec;
  logic [31:0]      word;
  logic [7:0]       b;
  logic             fire, emit;
  res_t             res_c;

  assign fire     = in_valid && res_ready;
  assign in_pop   = fire;
  assign b        = in_item.byte_value;
  assign clen_dec = clen_r - 32'd1;
  assign drem_dec = drem_r - 32'd1;

  always_comb begin
    phase_v = phase_r;
    cnt_v   = cnt_r;
    shift_v = shift_r;
    fmt_v   = fmt_r;
    chan_v  = chan_r;
    rate_v  = rate_r;
    bits_v  = bits_r;
    if (in_item.file_start) begin
      phase_v = PH_RIFF_ID;
      cnt_v   = '0;
      shift_v = '0;
      fmt_v   = '0;
      chan_v  = '0;
      rate_v  = '0;
      bits_v  = '0;
    end

    word      = {b, shift_v[31:8]};
    phase_nxt = phase_v;
    cnt_nxt   = cnt_v;
    shift_nxt = shift_v;
    tag_nxt   = tag_r;
    clen_nxt  = clen_r;
    fmt_nxt   = fmt_v;
    chan_nxt  = chan_v;
    rate_nxt  = rate_v;
    bits_nxt  = bits_v;
    drem_nxt  = drem_r;
    emit      = 1'b0;
    res_c     = '0;

    unique case (phase_v) inside
      PH_WAIT: begin
      end
      PH_RIFF_ID, PH_RIFF_SIZE, PH_WAVE_ID, PH_CHUNK_ID, PH_CHUNK_SIZE: begin
        shift_nxt = word;
        if (cnt_v == CNT_W'(3)) begin
          cnt_nxt = '0;
          unique case (phase_v)
            PH_RIFF_ID: begin
              if (word != TAG_RIFF) begin
                emit             = 1'b1;
                res_c.kind       = KIND_ERROR;
                res_c.error_code = ERR_RIFF;
                phase_nxt        = PH_WAIT;
              end else begin
                phase_nxt = PH_RIFF_SIZE;
              end
            end
            PH_RIFF_SIZE: phase_nxt = PH_WAVE_ID;
            PH_WAVE_ID: begin
              if (word != TAG_WAVE) begin
                emit             = 1'b1;
                res_c.kind       = KIND_ERROR;
                res_c.error_code = ERR_WAVE;
                phase_nxt        = PH_WAIT;
              end else begin
                phase_nxt = PH_CHUNK_ID;
              end
            end
            PH_CHUNK_ID: begin
              tag_nxt   = word;
              phase_nxt = PH_CHUNK_SIZE;
            end
            default: begin
              clen_nxt = word;
              if (tag_r == TAG_FMT) begin
                fmt_nxt   = '0;
                chan_nxt  = '0;
                rate_nxt  = '0;
                bits_nxt  = '0;
                phase_nxt = PH_FMT_BODY;
              end else if (tag_r == TAG_DATA) begin
                drem_nxt            = word;
                emit                = 1'b1;
                res_c.kind          = KIND_HEADER;
                res_c.format_code   = fmt_v;
                res_c.channel_count = chan_v;
                res_c.sample_rate   = rate_v;
                res_c.sample_bits   = bits_v;
                res_c.data_length   = word;
                phase_nxt           = (word != '0) ? PH_DATA : PH_WAIT;
              end else begin
                phase_nxt = (word != '0) ? PH_SKIP : PH_CHUNK_ID;
              end
            end
          endcase
        end else begin
          cnt_nxt = cnt_v + 1'b1;
        end
      end
      PH_FMT_BODY: begin
        case (cnt_v) inside
          CNT_W'(0):  fmt_nxt[7:0]    = b;
          CNT_W'(1):  fmt_nxt[15:8]   = b;
          CNT_W'(2):  chan_nxt[7:0]   = b;
          CNT_W'(3):  chan_nxt[15:8]  = b;
          CNT_W'(4):  rate_nxt[7:0]   = b;
          CNT_W'(5):  rate_nxt[15:8]  = b;
          CNT_W'(6):  rate_nxt[23:16] = b;
          CNT_W'(7):  rate_nxt[31:24] = b;
          CNT_W'(14): bits_nxt[7:0]   = b;
          CNT_W'(15): bits_nxt[15:8]  = b;
          default: begin
          end
        endcase
        if (cnt_v == CNT_W'(FMT_BODY_BYTES - 1)) begin
          cnt_nxt = '0;
          if (clen_r > 32'(FMT_BODY_BYTES)) begin
            clen_nxt  = clen_r - 32'(FMT_BODY_BYTES);
            phase_nxt = PH_SKIP;
          end else begin
            phase_nxt = PH_CHUNK_ID;
          end
        end else begin
          cnt_nxt = cnt_v + 1'b1;
        end
      end
      PH_SKIP: begin
        clen_nxt = clen_dec;
        if (clen_dec == '0) begin
          phase_nxt = PH_CHUNK_ID;
        end
      end
      PH_DATA: begin
        emit              = 1'b1;
        res_c.kind        = KIND_SAMPLE;
        res_c.sample_byte = b;
        res_c.last_sample = (drem_r == 32'd1);
        drem_nxt          = drem_dec;
        if (drem_dec == '0) begin
          phase_nxt = PH_WAIT;
        end
      end
      default: phase_nxt = PH_WAIT;
    endcase

    // A file that ends while still inside the header is reported as cut short,
    // unless this byte already gave a result.
    if (in_item.file_end) begin
      if (!emit && (phase_nxt >= PH_RIFF_ID) && (phase_nxt <= PH_SKIP)) begin
        emit             = 1'b1;
        res_c            = '0;
        res_c.kind       = KIND_ERROR;
        res_c.error_code = ERR_TRUNC;
      end
      phase_nxt = PH_WAIT;
    end
  end

  assign res_valid = fire && emit;
  assign res       = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      cnt_r   <= '0;
      shift_r <= '0;
      tag_r   <= '0;
      clen_r  <= '0;
      fmt_r   <= '0;
      chan_r  <= '0;
      rate_r  <= '0;
      bits_r  <= '0;
      drem_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      tag_r   <= tag_nxt;
      clen_r  <= clen_nxt;
      fmt_r   <= fmt_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      drem_r  <= drem_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/wrrp_res_q.sv -----
`default_nettype none

module wrrp_res_q (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire wrrp_pkg::res_t item,
  output logic                full,
  output logic                empty,
  output wrrp_pkg::res_t      head,
  input  wire logic           pop
);
  import wrrp_pkg::*;

  res_t              mem_r [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

// ----- src/wav_riff_header_parser.sv -----
// Path: a byte accepted into the front queue is parsed when the parser pops it, and its result,
// if any, is written into the result queue, from which it is popped; the parser waits while
// the result queue is full.
// Throughput: one byte per cycle, sustained while the result queue has room, set by the parser
// step and the two-entry queues either side of it.
// Reset: synchronous, active low; both queues empty and the parser waits for a file start.
`default_nettype none

module wav_riff_header_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_file_start,
  input  wire logic        in_file_end,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_sample_byte,
  output logic             out_last_sample,
  output logic [15:0]      out_format_code,
  output logic [15:0]      out_channel_count,
  output logic [31:0]      out_sample_rate,
  output logic [15:0]      out_sample_bits,
  output logic [31:0]      out_data_length,
  output logic [1:0]       out_error_code
);
  import wrrp_pkg::*;

  // The front queue takes each incoming beat and holds it for the parser; when
  // the parser stalls and the queue fills, in_full holds the upstream side back.
  in_item_t in_item;
  in_item_t fq_head;
  logic     fq_valid;
  logic     fq_pop;

  // The parser steps through the RIFF header and data one byte per cycle while
  // the result queue has room, and writes at most one result per byte there.
  res_t     res;
  res_t     rq_head;
  logic     res_valid;
  logic     rq_full;

  assign in_item.byte_value = in_byte_value;
  assign in_item.file_start = in_file_start;
  assign in_item.file_end   = in_file_end;

  wrrp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .item  (in_item),
    .full  (in_full),
    .valid (fq_valid),
    .head  (fq_head),
    .pop   (fq_pop)
  );

  // The parser only advances when the result queue has room, so a stalled
  // consumer backs up into the front queue and from there onto in_full.
  wrrp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_item   (fq_head),
    .in_pop    (fq_pop),
    .res_ready (!rq_full),
    .res_valid (res_valid),
    .res       (res)
  );

  wrrp_res_q u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .item  (res),
    .full  (rq_full),
    .empty (out_empty),
    .head  (rq_head),
    .pop   (out_pop)
  );

  // The oldest waiting result is shown directly from the queue storage.
  assign out_kind          = rq_head.kind;
  assign out_sample_byte   = rq_head.sample_byte;
  assign out_last_sample   = rq_head.last_sample;
  assign out_format_code   = rq_head.format_code;
  assign out_channel_count = rq_head.channel_count;
  assign out_sample_rate   = rq_head.sample_rate;
  assign out_sample_bits   = rq_head.sample_bits;
  assign out_data_length   = rq_head.data_length;
  assign out_error_code    = rq_head.error_code;

endmodule

`default_nettype wire

// ----- src/wrrp_checker.sv -----
`default_nettype none

module wrrp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [1:0]  out_kind,
  input wire logic        out_last_sample,
  input wire logic [31:0] out_data_length
);
  import wrrp_pkg::*;

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> out_empty && !in_full)
    else $error("queues not empty after reset");

  // The input side only fills up after a beat was pushed.
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("input side became full without a push");

  // A waiting result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_kind)
      && $stable(out_data_length))
    else $error("waiting result changed or vanished");

  // Only sample beats carry the end-of-data mark, and only valid kinds appear.
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_kind == KIND_SAMPLE || out_kind == KIND_HEADER
      || out_kind == KIND_ERROR) && (out_kind == KIND_SAMPLE || !out_last_sample))
    else $error("bad result kind or stray last-sample mark");

endmodule

bind wav_riff_header_parser wrrp_checker u_wrrp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_push         (in_push),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_kind        (out_kind),
  .out_last_sample (out_last_sample),
  .out_data_length (out_data_length)
);

`default_nettype wire
